// ===== hdl/c40te_pkg.sv =====
// Package with the C40 triplet encoder types, constants and value mapping functions.
`timescale 1ns / 1ps
`default_nettype none
package c40te_pkg;

    // Input command codes.
    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    // Result kind codes.
    typedef enum logic {
        KIND_CODEWORD = 1'b0,
        KIND_LEFTOVER = 1'b1
    } t_kind;

    // One input request.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] char_code;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] codeword;
        t_kind      kind;
        logic       last;
    } t_out_item;

    // Up to four C40 values produced by one byte, first value at index 0.
    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][5:0]  v;
    } t_map;

    localparam logic [7:0] C_UNLATCH     = 8'd254;
    localparam logic [5:0] C_SHIFT1      = 6'd0;
    localparam logic [5:0] C_SHIFT2      = 6'd1;
    localparam logic [5:0] C_SHIFT3      = 6'd2;
    localparam logic [5:0] C_UPPER_SHIFT = 6'd30;
    localparam logic [5:0] C_SPACE_VAL   = 6'd3;

    // Map a 7-bit character onto the basic set with an optional shift prefix.
    function automatic t_map map_basic(input logic [6:0] b);
        t_map m;
        m = '0;
        if (b == 7'd32) begin
            m.cnt  = 3'd1;
            m.v[0] = C_SPACE_VAL;
        end else if (b >= 7'd48 && b <= 7'd57) begin
            m.cnt  = 3'd1;
            m.v[0] = 6'(b - 7'd44);
        end else if (b >= 7'd65 && b <= 7'd90) begin
            m.cnt  = 3'd1;
            m.v[0] = 6'(b - 7'd51);
        end else if (b <= 7'd31) begin
            m.cnt  = 3'd2;
            m.v[0] = C_SHIFT1;
            m.v[1] = 6'(b);
        end else if (b >= 7'd33 && b <= 7'd47) begin
            m.cnt  = 3'd2;
            m.v[0] = C_SHIFT2;
            m.v[1] = 6'(b - 7'd33);
        end else if (b >= 7'd58 && b <= 7'd64) begin
            m.cnt  = 3'd2;
            m.v[0] = C_SHIFT2;
            m.v[1] = 6'(b - 7'd43);
        end else if (b >= 7'd91 && b <= 7'd95) begin
            m.cnt  = 3'd2;
            m.v[0] = C_SHIFT2;
            m.v[1] = 6'(b - 7'd69);
        end else begin
            m.cnt  = 3'd2;
            m.v[0] = C_SHIFT3;
            m.v[1] = {1'b0, b[4:0]};
        end
        return m;
    endfunction

    // Map a full byte; bytes of 128 and above get the upper-shift prefix.
    function automatic t_map map_byte(input logic [7:0] b);
        t_map base;
        t_map m;
        base = map_basic(b[6:0]);
        m    = base;
        if (b[7]) begin
            m.cnt  = base.cnt + 3'd2;
            m.v[0] = C_SHIFT2;
            m.v[1] = C_UPPER_SHIFT;
            m.v[2] = base.v[0];
            m.v[3] = base.v[1];
        end
        return m;
    endfunction

    // Pack one triplet as 1600a + 40b + c + 1.
    function automatic logic [15:0] pack(input logic [5:0] a, input logic [5:0] b,
                                         input logic [5:0] c);
        return {10'd0, a} * 16'd1600 + {10'd0, b} * 16'd40 + {10'd0, c} + 16'd1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/c40_text_triplet_encoder.sv =====
// C40 text triplet encoder: input register, single-pass mapping and packing, result buffer.
//
//  Channel | Direction | Signals                               | Moves
//  --------+-----------+---------------------------------------+---------------------------
//  in      | in        | i_in_valid, o_in_ready, i_in_data     | one byte or flush request
//  out     | out       | o_out_valid, i_out_ready, o_out_data  | one codeword result
//
// A request is registered, then mapped and packed combinationally into a four-entry result buffer.
// The result buffer drains one result per cycle through its single output port,
// stalling while i_out_ready is low.
// A new request is loaded while the last result of the previous one is being taken.
// Reset clears the valid flags, the buffer count and the pending count.
// Stalls on the output hold the buffer and back up into the input register.
`timescale 1ns / 1ps
`default_nettype none
module c40_text_triplet_encoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire c40te_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output c40te_pkg::t_out_item  o_out_data
);
    import c40te_pkg::*;

    // Input register.
    logic            r_in_vld;
    t_in_item        r_in;

    // Pending values and their count.
    logic [1:0][5:0] r_pend;
    logic [1:0]      r_pend_cnt;

    // Result buffer, head at index 0.
    t_out_item       r_res [4];
    logic [2:0]      r_cnt;

    // Combinational values.
    logic            pop;
    logic            load;
    t_map            mv;
    logic [1:0]      n_eff;
    logic [5:0][5:0] vals;
    logic [2:0]      total;
    logic [1:0]      ntrip;
    logic [15:0]     pk0;
    logic [15:0]     pk1;
    logic [15:0]     pkf;
    t_out_item       n_res [4];
    logic [2:0]      n_cnt;
    logic [1:0][5:0] n_pend;
    logic [1:0]      n_pend_cnt;

    // Handshake control.
    assign pop         = o_out_valid && i_out_ready;
    assign load        = r_in_vld && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && pop));
    assign o_in_ready  = !r_in_vld || load;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_res[0];

    // Line up pending values ahead of the new byte's values.
    always_comb begin
        mv = map_byte(r_in.char_code);
        unique case (r_pend_cnt)
            2'd0:    begin
                n_eff = 2'd0;
                vals  = {12'd0, mv.v};
            end
            2'd1:    begin
                n_eff = 2'd1;
                vals  = {6'd0, mv.v, r_pend[0]};
            end
            default: begin
                n_eff = 2'd2;
                vals  = {mv.v, r_pend};
            end
        endcase
        total = {1'b0, n_eff} + mv.cnt;
        if (total >= 3'd6) begin
            ntrip = 2'd2;
        end else if (total >= 3'd3) begin
            ntrip = 2'd1;
        end else begin
            ntrip = 2'd0;
        end
        pk0 = pack(vals[0], vals[1], vals[2]);
        pk1 = pack(vals[3], vals[4], vals[5]);
        pkf = pack(r_pend[0], r_pend[1], 6'd0);
    end

    // Build the results and next pending state for the registered request.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_res[i] = '{codeword: 8'd0, kind: KIND_CODEWORD, last: 1'b0};
        end
        n_cnt      = 3'd0;
        n_pend     = vals[1:0];
        n_pend_cnt = 2'd0;
        if (r_in.cmd == CMD_ENCODE) begin
            n_res[0].codeword = pk0[15:8];
            n_res[1].codeword = pk0[7:0];
            n_res[2].codeword = pk1[15:8];
            n_res[3].codeword = pk1[7:0];
            unique case (ntrip)
                2'd0:    begin
                    n_cnt      = 3'd0;
                    n_pend     = vals[1:0];
                    n_pend_cnt = total[1:0];
                end
                2'd1:    begin
                    n_cnt         = 3'd2;
                    n_res[1].last = 1'b1;
                    n_pend        = vals[4:3];
                    n_pend_cnt    = 2'(total - 3'd3);
                end
                default: begin
                    n_cnt         = 3'd4;
                    n_res[3].last = 1'b1;
                    n_pend_cnt    = 2'd0;
                end
            endcase
        end else begin
            // Flush closes the segment and empties the pending values.
            unique case (n_eff)
                2'd2:    begin
                    n_cnt             = 3'd3;
                    n_res[0].codeword = pkf[15:8];
                    n_res[1].codeword = pkf[7:0];
                    n_res[2].codeword = C_UNLATCH;
                    n_res[2].last     = 1'b1;
                end
                2'd1:    begin
                    n_cnt         = 3'd1;
                    n_res[0].kind = KIND_LEFTOVER;
                    n_res[0].last = 1'b1;
                end
                default: begin
                    n_cnt             = 3'd1;
                    n_res[0].codeword = C_UNLATCH;
                    n_res[0].last     = 1'b1;
                end
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Pending count and result count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_cnt      <= 3'd0;
        end else if (load) begin
            r_pend_cnt <= n_pend_cnt;
            r_cnt      <= n_cnt;
        end else if (pop) begin
            r_cnt      <= r_cnt - 3'd1;
        end
    end

    // Pending values and result buffer payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pend <= n_pend;
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= n_res[i];
            end
        end else if (pop) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

    // The buffer never holds more than one request's results.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4 && r_pend_cnt <= 2'd2)
        else $error("result or pending count out of range");

    // A result marked last is the only one left in the buffer.
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (r_cnt == 3'd1))
        else $error("last result not at the end of the buffer");

    // The last result in the buffer always carries the last mark.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd1) |-> o_out_data.last)
        else $error("final buffered result lacks the last mark");

    // Every flush empties the pending values.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in.cmd == CMD_FLUSH) |=> (r_pend_cnt == 2'd0))
        else $error("pending values left after flush");

    // A result set is loaded only into an empty buffer or over its last result as that is taken.
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_cnt == 3'd0 || (r_cnt == 3'd1 && pop)))
        else $error("results loaded over undelivered results");

endmodule
`default_nettype wire
